// ===== sv/pst_pkg.sv =====
// Package for the paired A/B sign-test comparator.
// Holds sizes, result codes, register indexes and the controller/datapath
// command and status structs. No dependencies.
package pst_pkg;

	// Sizing of the block.
	localparam int PAIR_CAP   = 32;
	localparam int RATE_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Field widths fixed by the interface.
	localparam int RATE_IN_W = 32;
	localparam int SHAPE_W   = 24;
	localparam int THR_W     = 18;
	localparam int CNT_W     = 6;
	localparam int MED_W     = 19;
	localparam int VERD_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;

	// Derived datapath widths.
	localparam int GAIN_W = FRAC_BITS + 3;
	localparam int QUO_W  = FRAC_BITS + 2;
	localparam int DS_W   = $clog2(QUO_W);
	localparam int GA_W   = (PAIR_CAP > 1) ? $clog2(PAIR_CAP) : 1;
	localparam int RA_W   = $clog2(PAIR_CAP + 1);
	localparam int ROW_W  = PAIR_CAP + 1;
	localparam int SUM_W  = PAIR_CAP + 2;
	localparam int SV_W   = SUM_W + 5;
	localparam int CMP_W  = ((GAIN_W > THR_W) ? GAIN_W : THR_W) + 2;

	// Stream payload widths, padded to whole bytes.
	localparam int S_DATA_W = ((RATE_IN_W + SHAPE_W + THR_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((VERD_W + 4 * CNT_W + MED_W + 7) / 8) * 8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_B = 2'd1;

	// Verdict codes.
	localparam logic [VERD_W-1:0] VERDICT_NEED = 2'd0;
	localparam logic [VERD_W-1:0] VERDICT_B    = 2'd1;
	localparam logic [VERD_W-1:0] VERDICT_A    = 2'd2;
	localparam logic [VERD_W-1:0] VERDICT_FLAT = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic div_step;
		logic ins_wr;
		logic sw_init;
		logic sw_acc;
		logic med_a;
		logic med_b;
		logic med_c;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic store;
		logic div_last;
		logic ins_shift;
		logic sw_run;
		logic sw_last;
	} sts_t;

endpackage

// ===== sv/paired_ab_sign_test_comparator.sv =====
// Paired A/B sign-test comparator, top level.
// Use: program shape_a_code (index 0) and shape_b_code (index 1) on the write
// port while the block is idle; either write clears pairs, counts and the
// pending window. Windows enter on the s_axis channel, one result per window
// leaves on the m_axis channel.
// An A-shaped window is paired with the next B-shaped one (or the reverse);
// each stored pair adds a relative gain to a sorted store and updates the
// win counts, and every result carries the sign-test verdict and median.
// Steps per window, from accept to result valid: capture, decision, gain
// division (one quotient bit a cycle, only for non-ties), sorted insert
// (only when a pair is stored), binomial row sweep over n = a wins + b wins
// (only while the store holds pairs), median read and result load.
// The block takes one window at a time; s_axis_tready is high only while
// it is idle.
// A finished result sits in an output register: the next window is accepted
// while it waits, and the block holds its new result until m_axis_tready.
// Reset clears configuration, counters and the output valid flag; memories
// need no clearing pass since only entries below the counts are read.
// Depends on pst_pkg, pst_ctrl and pst_dp.
module paired_ab_sign_test_comparator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// window_rate[31:0], window_shape[55:32], noise_threshold[73:56], zero pad
	input  logic [pst_pkg::S_DATA_W-1:0]   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// verdict[1:0], pair_count[7:2], a_win_count[13:8], b_win_count[19:14],
	// tie_count[25:20], median_gain[44:26], zero pad
	output logic [pst_pkg::M_DATA_W-1:0]   m_axis_tdata,
	// pair_formed[0]
	output logic                           m_axis_tuser,
	input  logic                           cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pst_pkg::CFG_W-1:0]      cfg_data
);
	import pst_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [VERD_W-1:0]        verdict;
	logic [CNT_W-1:0]         pair_count, a_win_count, b_win_count, tie_count;
	logic signed [MED_W-1:0]  median_gain;

	pst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pst_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_rate    (s_axis_tdata[RATE_IN_W-1:0]),
		.in_shape   (s_axis_tdata[RATE_IN_W+SHAPE_W-1:RATE_IN_W]),
		.in_thr     (s_axis_tdata[RATE_IN_W+SHAPE_W+THR_W-1:RATE_IN_W+SHAPE_W]),
		.pair_formed(m_axis_tuser),
		.verdict    (verdict),
		.pair_count (pair_count),
		.a_win_count(a_win_count),
		.b_win_count(b_win_count),
		.tie_count  (tie_count),
		.median_gain(median_gain)
	);

	// Pack the result fields, verdict lowest and median highest.
	assign m_axis_tdata = M_DATA_W'({median_gain, tie_count, b_win_count, a_win_count,
		pair_count, verdict});

endmodule

// ===== sv/pst_ctrl.sv =====
// Controller of the paired A/B sign-test comparator.
// Sequences capture, division, sorted insert, binomial sweep and median read.
// Depends on pst_pkg.
module pst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pst_pkg::sts_t sts,
	output pst_pkg::cmd_t cmd
);
	import pst_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECIDE, ST_DIV, ST_INS_A, ST_INS_B, ST_SW_INIT,
		ST_SW_A, ST_SW_B, ST_MED_A, ST_MED_B, ST_MED_C, ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign load_ok   = !out_valid_q || out_ready;

	// Command decode from the current state.
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.ins_wr   = (state_q == ST_INS_B);
		cmd.sw_init  = (state_q == ST_SW_INIT);
		cmd.sw_acc   = (state_q == ST_SW_B);
		cmd.med_a    = (state_q == ST_MED_A);
		cmd.med_b    = (state_q == ST_MED_B);
		cmd.med_c    = (state_q == ST_MED_C);
		cmd.load     = (state_q == ST_FIN) && load_ok;
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (sts.need_div) state_q <= ST_DIV;
					else if (sts.store) state_q <= ST_INS_A;
					else if (sts.sw_run) state_q <= ST_SW_INIT;
					else state_q <= ST_FIN;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_INS_A;
				end
				ST_INS_A: state_q <= ST_INS_B;
				ST_INS_B: begin
					if (sts.ins_shift) state_q <= ST_INS_A;
					else if (sts.sw_run) state_q <= ST_SW_INIT;
					else state_q <= ST_FIN;
				end
				ST_SW_INIT: state_q <= ST_SW_A;
				ST_SW_A: state_q <= ST_SW_B;
				ST_SW_B: begin
					if (sts.sw_last) state_q <= ST_MED_A;
					else state_q <= ST_SW_A;
				end
				ST_MED_A: state_q <= ST_MED_B;
				ST_MED_B: state_q <= ST_MED_C;
				ST_MED_C: state_q <= ST_FIN;
				ST_FIN: begin
					if (load_ok) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/pst_dp.sv =====
// Datapath of the paired A/B sign-test comparator.
// Pairing state, counters, radix-2 gain divider, sorted gain memory,
// binomial row memory and result registers. Depends on pst_pkg.
module pst_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pst_pkg::cmd_t                   cmd,
	output pst_pkg::sts_t                   sts,
	input  logic                            cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pst_pkg::CFG_W-1:0]       cfg_data,
	input  logic [pst_pkg::RATE_IN_W-1:0]   in_rate,
	input  logic [pst_pkg::SHAPE_W-1:0]     in_shape,
	input  logic [pst_pkg::THR_W-1:0]       in_thr,
	output logic                            pair_formed,
	output logic [pst_pkg::VERD_W-1:0]      verdict,
	output logic [pst_pkg::CNT_W-1:0]       pair_count,
	output logic [pst_pkg::CNT_W-1:0]       a_win_count,
	output logic [pst_pkg::CNT_W-1:0]       b_win_count,
	output logic [pst_pkg::CNT_W-1:0]       tie_count,
	output logic signed [pst_pkg::MED_W-1:0] median_gain
);
	import pst_pkg::*;

	// Configuration and pairing state.
	logic [SHAPE_W-1:0]    shape_a_q, shape_b_q, pend_shape_q;
	logic                  pend_valid_q;
	logic [RATE_WIDTH-1:0] pend_rate_q;
	logic [CNT_W-1:0]      cnt_q, aw_q, bw_q, tie_q;
	logic [THR_W-1:0]      thr_q;
	logic                  formed_q, store_q, need_div_q, neg_q, grew_q, lowbit_q;

	// Divider state.
	logic [RATE_WIDTH:0]   den_q, rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic [DS_W-1:0]       dstep_q;
	logic signed [GAIN_W-1:0] gain_q;

	// Insert, sweep and median state.
	logic [GA_W-1:0]       j_q;
	logic [RA_W-1:0]       k_q;
	logic [ROW_W-1:0]      hi_q;
	logic [SUM_W-1:0]      suma_q, sumb_q;
	logic signed [GAIN_W-1:0] mlo_q, median_q, grd_q;
	logic [VERD_W-1:0]     verdict_q;
	logic [ROW_W-1:0]      rrd_q;

	// Memories.
	logic signed [GAIN_W-1:0] gmem [PAIR_CAP];
	logic [ROW_W-1:0]         rmem [PAIR_CAP+1];

	// Capture-time decisions.
	logic [RATE_WIDTH-1:0] rate_c, a_c, b_c, mag_c;
	logic [RATE_WIDTH:0]   den_c;
	logic active, open_c, is_a_c, is_b_c, pair_c, store_c, bgt_c, agt_c, cfg_clr;

	assign rate_c  = RATE_WIDTH'(in_rate);
	assign active  = (shape_a_q != shape_b_q);
	assign open_c  = active && (cnt_q < CNT_W'(PAIR_CAP));
	assign is_a_c  = (in_shape == shape_a_q);
	assign is_b_c  = (in_shape == shape_b_q);
	assign pair_c  = open_c && (is_a_c || is_b_c) && pend_valid_q && (pend_shape_q != in_shape);
	assign a_c     = is_a_c ? rate_c : pend_rate_q;
	assign b_c     = is_b_c ? rate_c : pend_rate_q;
	assign den_c   = {1'b0, a_c} + {1'b0, b_c};
	assign store_c = pair_c && (den_c != '0);
	assign bgt_c   = (b_c > a_c);
	assign agt_c   = (a_c > b_c);
	assign mag_c   = bgt_c ? (b_c - a_c) : (a_c - b_c);
	assign cfg_clr = cfg_we && ((cfg_index == REG_SHAPE_A) || (cfg_index == REG_SHAPE_B));

	// One restoring division step.
	logic [RATE_WIDTH+1:0] div_t;
	logic [RATE_WIDTH+1:0] div_d;
	logic                  div_ge;
	logic [QUO_W-1:0]      quo_n;
	logic signed [GAIN_W-1:0] qext;

	assign div_t  = {rem_q, (dstep_q == '0) ? lowbit_q : 1'b0};
	assign div_ge = (div_t >= {1'b0, den_q});
	assign div_d  = div_t - {1'b0, den_q};
	assign quo_n  = {quo_q[QUO_W-2:0], div_ge};
	assign qext   = GAIN_W'({1'b0, quo_n});

	// Sorted insert compare and median-side addresses.
	logic [GA_W-1:0] gaddr;
	logic [CNT_W-1:0] c_m1;
	logic ins_shift;

	assign c_m1      = cnt_q - CNT_W'(1);
	assign ins_shift = (j_q != '0) && (grd_q > gain_q);
	always_comb begin
		if (cmd.med_a) gaddr = GA_W'(c_m1 >> 1);
		else if (cmd.med_b) gaddr = GA_W'(cnt_q >> 1);
		else gaddr = j_q - GA_W'(1);
	end

	// Binomial sweep arithmetic.
	logic [CNT_W-1:0] n_c;
	logic [RA_W-1:0]  raddr;
	logic [ROW_W-1:0] lo_c, newv_c;
	logic [SV_W-1:0]  pow_c, a20_c, b20_c;
	logic sig_a, sig_b;

	assign n_c    = aw_q + bw_q;
	assign raddr  = (k_q == '0) ? '0 : (k_q - RA_W'(1));
	assign lo_c   = (k_q == '0) ? '0 : ((k_q == RA_W'(1)) ? ROW_W'(1) : rrd_q);
	assign newv_c = hi_q + (grew_q ? lo_c : '0);
	assign pow_c  = SV_W'(1) << n_c;
	assign a20_c  = (SV_W'(suma_q) << 4) + (SV_W'(suma_q) << 2);
	assign b20_c  = (SV_W'(sumb_q) << 4) + (SV_W'(sumb_q) << 2);
	assign sig_a  = (a20_c < pow_c);
	assign sig_b  = (b20_c < pow_c);

	// Median and verdict.
	logic signed [GAIN_W:0]   msum_c;
	logic signed [GAIN_W-1:0] med_c;
	logic signed [CMP_W-1:0]  medx_c, thrx_c;
	logic [VERD_W-1:0]        verd_c;

	assign msum_c = GAIN_W'(0) + ({mlo_q[GAIN_W-1], mlo_q} + {grd_q[GAIN_W-1], grd_q});
	assign med_c  = cnt_q[0] ? mlo_q : GAIN_W'(msum_c >>> 1);
	assign medx_c = CMP_W'(med_c);
	assign thrx_c = signed'(CMP_W'(thr_q));
	always_comb begin
		if ((n_c != '0) && sig_b && (medx_c > thrx_c)) verd_c = VERDICT_B;
		else if ((n_c != '0) && sig_a && (-medx_c > thrx_c)) verd_c = VERDICT_A;
		else if (cnt_q >= CNT_W'(PAIR_CAP)) verd_c = VERDICT_FLAT;
		else verd_c = VERDICT_NEED;
	end

	assign sts.need_div  = need_div_q;
	assign sts.store     = store_q;
	assign sts.div_last  = (dstep_q == DS_W'(QUO_W - 1));
	assign sts.ins_shift = ins_shift;
	assign sts.sw_run    = active && (cnt_q != '0);
	assign sts.sw_last   = (k_q == '0);

	// Control registers: configuration, pending window and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_a_q    <= '0;
			shape_b_q    <= '0;
			pend_valid_q <= 1'b0;
			pend_shape_q <= '0;
			pend_rate_q  <= '0;
			cnt_q        <= '0;
			aw_q         <= '0;
			bw_q         <= '0;
			tie_q        <= '0;
		end else if (cfg_clr) begin
			if (cfg_index == REG_SHAPE_A) shape_a_q <= SHAPE_W'(cfg_data);
			else shape_b_q <= SHAPE_W'(cfg_data);
			pend_valid_q <= 1'b0;
			pend_shape_q <= '0;
			pend_rate_q  <= '0;
			cnt_q        <= '0;
			aw_q         <= '0;
			bw_q         <= '0;
			tie_q        <= '0;
		end else if (cmd.capture && open_c) begin
			if (!(is_a_c || is_b_c)) begin
				pend_valid_q <= 1'b0;
			end else if (!pend_valid_q) begin
				pend_valid_q <= 1'b1;
				pend_shape_q <= in_shape;
				pend_rate_q  <= rate_c;
			end else if (pend_shape_q == in_shape) begin
				pend_rate_q <= rate_c;
			end else begin
				pend_valid_q <= 1'b0;
			end
			if (store_c) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (bgt_c) bw_q <= bw_q + CNT_W'(1);
				else if (agt_c) aw_q <= aw_q + CNT_W'(1);
				else tie_q <= tie_q + CNT_W'(1);
			end
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			formed_q   <= store_c;
			store_q    <= store_c;
			need_div_q <= store_c && (bgt_c || agt_c);
			grew_q     <= store_c && (bgt_c || agt_c);
			neg_q      <= agt_c;
			den_q      <= den_c;
			rem_q      <= (RATE_WIDTH + 1)'(mag_c >> 1);
			lowbit_q   <= mag_c[0];
			quo_q      <= '0;
			dstep_q    <= '0;
			gain_q     <= '0;
			j_q        <= GA_W'(cnt_q);
			thr_q      <= in_thr;
		end
		if (cmd.div_step) begin
			rem_q   <= div_ge ? div_d[RATE_WIDTH:0] : div_t[RATE_WIDTH:0];
			quo_q   <= quo_n;
			dstep_q <= dstep_q + DS_W'(1);
			if (sts.div_last) gain_q <= neg_q ? -qext : qext;
		end
		if (cmd.ins_wr && ins_shift) begin
			j_q <= j_q - GA_W'(1);
		end
		if (cmd.sw_init) begin
			k_q    <= RA_W'(n_c);
			hi_q   <= grew_q ? '0 : ROW_W'(1);
			suma_q <= '0;
			sumb_q <= '0;
		end
		if (cmd.sw_acc) begin
			if (CNT_W'(k_q) >= aw_q) suma_q <= suma_q + SUM_W'(newv_c);
			if (CNT_W'(k_q) >= bw_q) sumb_q <= sumb_q + SUM_W'(newv_c);
			hi_q <= lo_c;
			k_q  <= k_q - RA_W'(1);
		end
		if (cmd.med_b) begin
			mlo_q <= grd_q;
		end
		if (cmd.med_c) begin
			median_q  <= med_c;
			verdict_q <= verd_c;
		end
	end

	// Sorted gain memory: one write, one registered read.
	always_ff @(posedge clk) begin
		if (cmd.ins_wr) begin
			gmem[j_q] <= ins_shift ? grd_q : gain_q;
		end
		grd_q <= gmem[gaddr];
	end

	// Binomial row memory; entry zero is never written and its value is never used.
	always_ff @(posedge clk) begin
		if (cmd.sw_acc && grew_q && (k_q != '0)) begin
			rmem[k_q] <= newv_c;
		end
		rrd_q <= rmem[raddr];
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pair_formed <= formed_q;
			pair_count  <= cnt_q;
			a_win_count <= aw_q;
			b_win_count <= bw_q;
			tie_count   <= tie_q;
			verdict     <= sts.sw_run ? verdict_q : VERDICT_NEED;
			median_gain <= sts.sw_run ? MED_W'(median_q) : '0;
		end
	end

endmodule

// ===== sv/pst_checker.sv =====
// Port-level checker for the paired A/B sign-test comparator.
// Bound to the top level; depends on pst_pkg.
module pst_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [pst_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input logic                          m_axis_tuser
);
	import pst_pkg::*;

	logic [CNT_W-1:0] pc, ac, bc, tc;
	logic [CNT_W+1:0] total;

	assign pc    = m_axis_tdata[7:2];
	assign ac    = m_axis_tdata[13:8];
	assign bc    = m_axis_tdata[19:14];
	assign tc    = m_axis_tdata[25:20];
	assign total = (CNT_W + 2)'(ac) + (CNT_W + 2)'(bc) + (CNT_W + 2)'(tc);

	// A window transfer makes the block busy for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again right after a transfer");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Stored pairs are exactly the wins plus the ties.
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (total == (CNT_W + 2)'(pc)))
		else $error("pair count differs from wins plus ties");

	// With no stored pair there is neither verdict nor median.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (pc == '0) |-> (m_axis_tdata[1:0] == VERDICT_NEED)
		&& (m_axis_tdata[44:26] == '0) && !m_axis_tuser)
		else $error("empty store reported a verdict, median or pair");

endmodule

bind paired_ab_sign_test_comparator pst_checker u_pst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the paired A/B sign-test comparator.
// Predicts every result from a local copy of the pairing state; uses pst_pkg
// and the top level paired_ab_sign_test_comparator.
`timescale 1ns / 1ps

module testbench;
	import pst_pkg::*;

	typedef struct packed {
		logic [31:0] rate;
		logic [23:0] shape;
		logic [17:0] thr;
	} window_t;

	typedef struct packed {
		logic              formed;
		logic [1:0]        verdict;
		logic [5:0]        pairs;
		logic [5:0]        a_wins;
		logic [5:0]        b_wins;
		logic [5:0]        ties;
		logic signed [18:0] median;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Windows waiting to be sent; the head is the one on the bus.
	window_t window_q[$];
	outcome_t expected_outcomes[$];
	int errors = 0;
	bit quiet_tail = 1'b0;
	int idle_pct = 10;

	// Local copy of the comparator state.
	logic [23:0] shape_a_q = '0;
	logic [23:0] shape_b_q = '0;
	int gains[0:PAIR_CAP-1];
	int pairs_q, a_wins_q, b_wins_q, ties_q;
	bit pend_valid_q;
	logic [23:0] pend_shape_q;
	logic [31:0] pend_rate_q;

	paired_ab_sign_test_comparator uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_pairs();
		pairs_q = 0;
		a_wins_q = 0;
		b_wins_q = 0;
		ties_q = 0;
		pend_valid_q = 1'b0;
		pend_shape_q = '0;
		pend_rate_q = '0;
	endfunction

	// True when 20 times the upper binomial tail from w is below 2^n.
	function automatic bit tail_ok(int w, int n);
		longint unsigned row[0:63];
		longint unsigned total;
		total = 0;
		if (w > n)
			return 1'b0;
		for (int k = 0; k < 64; k++)
			row[k] = 0;
		row[0] = 1;
		for (int i = 1; i <= n; i++)
			for (int k = i; k > 0; k--)
				row[k] += row[k-1];
		for (int k = w; k <= n; k++)
			total += row[k];
		return total <= (((64'd1 << n) - 1) / 20);
	endfunction

	// Median of the stored gains; an even count takes the floor of the mean.
	function automatic longint median_now();
		int sorted[0:PAIR_CAP-1];
		int v, j;
		longint s;
		for (int i = 0; i < pairs_q; i++)
			sorted[i] = gains[i];
		for (int i = 1; i < pairs_q; i++) begin
			v = sorted[i];
			j = i;
			while (j != 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		if (pairs_q % 2)
			return sorted[pairs_q/2];
		s = longint'(sorted[pairs_q/2-1]) + longint'(sorted[pairs_q/2]);
		return s >>> 1;
	endfunction

	// Advances the local state by one window and returns the result it causes.
	function automatic outcome_t predict_window(window_t w);
		outcome_t r;
		longint unsigned a, b, den;
		longint med;
		bit active, is_a, is_b;
		int n, g;
		r = '0;
		med = 0;
		active = shape_a_q != shape_b_q;
		if (active && pairs_q < PAIR_CAP) begin
			is_a = w.shape == shape_a_q;
			is_b = w.shape == shape_b_q;
			if (!is_a && !is_b) begin
				pend_valid_q = 1'b0;
			end else if (!pend_valid_q) begin
				pend_valid_q = 1'b1;
				pend_shape_q = w.shape;
				pend_rate_q = w.rate;
			end else if (pend_shape_q == w.shape) begin
				pend_rate_q = w.rate;
			end else begin
				a = is_a ? w.rate : pend_rate_q;
				b = is_b ? w.rate : pend_rate_q;
				den = a + b;
				pend_valid_q = 1'b0;
				if (den != 0) begin
					if (b > a) begin
						g = int'(((b - a) << 17) / den);
						b_wins_q++;
					end else if (a > b) begin
						g = -int'(((a - b) << 17) / den);
						a_wins_q++;
					end else begin
						g = 0;
						ties_q++;
					end
					gains[pairs_q] = g;
					pairs_q++;
					r.formed = 1'b1;
				end
			end
		end
		r.verdict = VERDICT_NEED;
		if (active && pairs_q != 0) begin
			n = a_wins_q + b_wins_q;
			med = median_now();
			if (n != 0 && tail_ok(b_wins_q, n) && med > longint'(w.thr))
				r.verdict = VERDICT_B;
			else if (n != 0 && tail_ok(a_wins_q, n) && -med > longint'(w.thr))
				r.verdict = VERDICT_A;
			else if (pairs_q >= PAIR_CAP)
				r.verdict = VERDICT_FLAT;
		end
		r.pairs = pairs_q[5:0];
		r.a_wins = a_wins_q[5:0];
		r.b_wins = b_wins_q[5:0];
		r.ties = ties_q[5:0];
		r.median = med[18:0];
		return r;
	endfunction

	// Sender: offers the head of the window queue, with random gaps.
	int send_gap = 0;
	bit s_take;
	bit s_offer;
	always @(posedge clk) begin
		if (arst_n) begin
			s_take = s_axis_tvalid && s_axis_tready;
			if (s_take) begin
				expected_outcomes.push_back(predict_window(window_q.pop_front()));
			end
			if (s_axis_tvalid && !s_take) begin
				s_offer = 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				s_offer = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
				send_gap = $urandom_range(1, 15) - 1;
				s_offer = 1'b0;
			end else begin
				s_offer = window_q.size() != 0;
			end
			s_axis_tvalid <= s_offer;
			if (s_offer)
				s_axis_tdata <= {6'b0, window_q[0].thr, window_q[0].shape, window_q[0].rate};
		end
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Receiver: checks each result transfer, stalls at random and holds off
	// once for a long stretch so that the block backs up.
	int recv_gap = 0;
	int hold_left = 0;
	int results_seen = 0;
	bit m_take;
	bit m_ready;
	outcome_t want;
	outcome_t got;
	always @(posedge clk) begin
		if (arst_n) begin
			m_take = m_axis_tvalid && m_axis_tready;
			if (m_take) begin
				results_seen++;
				got.formed = m_axis_tuser;
				got.verdict = m_axis_tdata[1:0];
				got.pairs = m_axis_tdata[7:2];
				got.a_wins = m_axis_tdata[13:8];
				got.b_wins = m_axis_tdata[19:14];
				got.ties = m_axis_tdata[25:20];
				got.median = m_axis_tdata[44:26];
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected result transfer, actual %h", $time, m_axis_tdata);
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					check_field("pair_formed", want.formed, got.formed);
					check_field("verdict", want.verdict, got.verdict);
					check_field("pair_count", want.pairs, got.pairs);
					check_field("a_win_count", want.a_wins, got.a_wins);
					check_field("b_win_count", want.b_wins, got.b_wins);
					check_field("tie_count", want.ties, got.ties);
					check_field("median_gain", want.median, got.median);
				end
				if (results_seen == 300)
					hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_ready = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_ready = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
				recv_gap = $urandom_range(1, 15) - 1;
				m_ready = 1'b0;
			end else begin
				m_ready = 1'b1;
			end
			m_axis_tready <= m_ready;
		end
	end

	// Watchdog on cycles without any transfer.
	int stuck_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == 20000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SHAPE_A) begin
			shape_a_q = val;
			clear_pairs();
		end else if (idx == REG_SHAPE_B) begin
			shape_b_q = val;
			clear_pairs();
		end
	endtask

	// Waits until every window is sent and every result checked, then lets
	// the block settle before the next register write.
	task automatic drain();
		while (window_q.size() != 0 || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [17:0] pick_threshold();
		if ($urandom_range(0, 3) == 0)
			return 18'($urandom_range(0, 262143));
		return 18'($urandom_range(0, 8000));
	endfunction

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 255);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
			default: return $urandom_range(0, 1 << 20);
		endcase
	endfunction

	function automatic void send(logic [31:0] rate, logic [23:0] shape, logic [17:0] thr);
		window_t w;
		w.rate = rate;
		w.shape = shape;
		w.thr = thr;
		window_q.push_back(w);
	endfunction

	// One random phase: mostly well-formed A/B pairs, leaning toward one side
	// when lean is 1 or 2, with unrelated shapes and repeated windows mixed in.
	task automatic random_phase(int count, int lean);
		logic [31:0] a, b, delta;
		logic [17:0] thr;
		bit up;
		int sent;
		int r;
		sent = 0;
		thr = pick_threshold();
		while (sent < count) begin
			if ($urandom_range(0, 7) == 0)
				thr = pick_threshold();
			r = $urandom_range(0, 19);
			if (r == 0) begin
				send($urandom, 24'($urandom), thr);
				sent++;
			end else if (r == 1) begin
				send(pick_rate(), shape_a_q, thr);
				sent++;
			end else begin
				a = pick_rate();
				case ($urandom_range(0, 9))
					0: b = a;
					1: b = $urandom;
					default: begin
						up = (lean == 1) ? ($urandom_range(0, 5) != 0) :
							(lean == 2) ? ($urandom_range(0, 5) == 0) : $urandom_range(0, 1);
						delta = (a >> $urandom_range(1, 8)) + $urandom_range(0, 3);
						if (up)
							b = (a > 32'hFFFF_FFFF - delta) ? 32'hFFFF_FFFF : a + delta;
						else
							b = (a > delta) ? a - delta : 32'd0;
					end
				endcase
				if ($urandom_range(0, 3) != 0) begin
					send(a, shape_a_q, thr);
					send(b, shape_b_q, thr);
				end else begin
					send(b, shape_b_q, thr);
					send(a, shape_a_q, thr);
				end
				sent += 2;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < PAIR_CAP; i++)
			gains[i] = 0;
		clear_pairs();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Equal shape codes after reset: the comparator ignores windows.
		send(32'hFFFF_FFFF, 24'h0, 18'h3FFFF);
		send(32'd7, 24'hFFFFFF, 18'd0);
		drain();

		// Directed part with shape codes at their extremes.
		write_reg(REG_SHAPE_A, 24'h000000);
		write_reg(REG_SHAPE_B, 24'hFFFFFF);
		send(32'd0, 24'h000000, 18'd0);          // rates summing to zero
		send(32'd0, 24'hFFFFFF, 18'd0);
		send(32'hFFFF_FFFF, 24'h000000, 18'd0);  // tie at full scale
		send(32'hFFFF_FFFF, 24'hFFFFFF, 18'd131072);
		send(32'd1, 24'h000000, 18'd5);          // near full gain toward B
		send(32'hFFFF_FFFF, 24'hFFFFFF, 18'd5);
		send(32'hFFFF_FFFF, 24'h000000, 18'h3FFFF); // gain -2
		send(32'd0, 24'hFFFFFF, 18'h3FFFF);
		send(32'd5, 24'hFFFFFF, 18'd131071);     // B first, gain +2
		send(32'd0, 24'h000000, 18'd131071);
		send(32'd100, 24'h000000, 18'd0);        // same shape replaces
		send(32'd300, 24'h000000, 18'd0);
		send(32'd200, 24'hFFFFFF, 18'd0);
		send(32'd50, 24'hFFFFFF, 18'd0);         // unrelated shape clears
		send(32'd60, 24'h123456, 18'd0);
		send(32'd70, 24'h000000, 18'd0);
		send(32'd3, 24'hFFFFFF, 18'd0);
		drain();

		// An out-of-range register index leaves state alone.
		write_reg(2'd3, 24'hABCDEF);
		random_phase(40, 1);
		drain();

		write_reg(REG_SHAPE_A, 24'hFFFFFF);
		write_reg(REG_SHAPE_B, 24'h000000);
		random_phase(120, 2);
		drain();

		// Equal nonzero codes keep the comparator off.
		write_reg(REG_SHAPE_A, 24'h5A5A5A);
		write_reg(REG_SHAPE_B, 24'h5A5A5A);
		random_phase(20, 0);
		drain();

		for (int p = 0; p < 12; p++) begin
			idle_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 40);
			quiet_tail = (p >= 10);
			write_reg(REG_SHAPE_A, 24'($urandom));
			write_reg(REG_SHAPE_B, 24'($urandom));
			random_phase(120, p % 3);
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
